// ===== sv/gpsm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the game pad poll serial master.
// Holds phase codes, frame constants and the command byte lookup; no dependencies.
package gpsm_pkg;

    localparam int unsigned PHASE_W     = 2;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned REG_W       = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [REG_W-1:0]   t_reg;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_phase PH_IDLE  = 2'd0;
    localparam t_phase PH_SETUP = 2'd1;
    localparam t_phase PH_LOW   = 2'd2;
    localparam t_phase PH_HIGH  = 2'd3;

    localparam t_cfg_index CFG_BIT_HALF_PERIOD = 2'd0;
    localparam t_cfg_index CFG_ATTENTION_SETUP = 2'd1;

    localparam t_reg RST_BIT_HALF_PERIOD = 16'd15;
    localparam t_reg RST_ATTENTION_SETUP = 16'd20;

    localparam t_idx FRAME_BYTES    = 3'd5;
    localparam t_idx LAST_BIT       = 3'd7;
    localparam t_idx FIRST_BTN_BYTE = 3'd3;
    localparam t_idx SECOND_BTN_BYTE = 3'd4;

    localparam t_byte CMD_START = 8'h01;
    localparam t_byte CMD_POLL  = 8'h42;
    localparam t_byte CMD_IDLE  = 8'h00;

    // Command byte sent in each slot of the frame
    function automatic t_byte tx_byte(input t_idx idx);
        t_byte b;
        b = CMD_IDLE;
        if (idx == 3'd0) begin
            b = CMD_START;
        end else if (idx == 3'd1) begin
            b = CMD_POLL;
        end
        return b;
    endfunction

endpackage

// ===== sv/gamepad_poll_serial_master.sv =====
`timescale 1ns / 1ps
// Game pad poll serial master: one timing tick per beat, clock idles high.
// The result beat for a tick is offered in the cycle after that tick is taken.
// One tick per cycle unless the result stalls; the phase, counter and shift registers
// update in a single pass per tick, and the result is read straight from those registers.
// Reset (synchronous, active low): idle, attention high, counters and bytes cleared,
// registers back to half period 15 and setup 20.
module gamepad_poll_serial_master #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Tick channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_start_req,
    input  logic                   i_data_pin,
    // Result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_attention_pin,
    output logic                   o_clock_pin,
    output logic                   o_command_pin,
    output logic                   o_busy_res,
    output logic                   o_buttons_valid,
    output gpsm_pkg::t_byte        o_first_button_byte,
    output gpsm_pkg::t_byte        o_second_button_byte,
    // Configuration
    input  logic                   i_cfg_we,
    input  gpsm_pkg::t_cfg_index   i_cfg_index,
    input  gpsm_pkg::t_reg         i_cfg_data
);
    import gpsm_pkg::*;

    localparam int unsigned CW = COUNTER_WIDTH;
    localparam int unsigned LW = (CW > REG_W) ? CW : REG_W;

    typedef logic [CW-1:0] t_count;
    typedef logic [LW-1:0] t_len_ext;

    localparam t_count   CNT_MAX     = {CW{1'b1}};
    localparam t_len_ext CNT_MAX_EXT = t_len_ext'(CNT_MAX);
    localparam t_len_ext ONE_EXT     = t_len_ext'(1);

    t_reg   r_bit_half_period;
    t_reg   r_attention_setup;
    t_phase r_phase, n_phase;
    t_count r_wait_count, n_wait_count;
    t_idx   r_bit_index, n_bit_index;
    t_idx   r_byte_index, n_byte_index;
    t_byte  r_receive_shift, n_receive_shift;
    t_byte  r_held_first, n_held_first;
    t_byte  r_held_second, n_held_second;
    logic   r_buttons_valid, n_buttons_valid;
    logic   r_out_valid;

    logic   in_accept;
    t_reg   len_reg;
    t_len_ext len_ext;
    t_count len;
    t_count wait_inc;
    logic   count_done;
    t_idx   byte_inc;
    t_byte  cmd_byte;

    // A new tick enters whenever the result slot is empty or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Phase length: zero acts as one, saturate at the counter maximum
    always_comb begin
        len_reg = (r_phase == PH_SETUP) ? r_attention_setup : r_bit_half_period;
        len_ext = t_len_ext'(len_reg);
        if (len_ext == '0) begin
            len_ext = ONE_EXT;
        end else if (len_ext > CNT_MAX_EXT) begin
            len_ext = CNT_MAX_EXT;
        end
        len        = len_ext[CW-1:0];
        wait_inc   = (r_wait_count == CNT_MAX) ? r_wait_count : r_wait_count + t_count'(1);
        count_done = (wait_inc >= len);
        byte_inc   = r_byte_index + t_idx'(1);
    end

    always_comb begin
        n_phase         = r_phase;
        n_wait_count    = r_wait_count;
        n_bit_index     = r_bit_index;
        n_byte_index    = r_byte_index;
        n_receive_shift = r_receive_shift;
        n_held_first    = r_held_first;
        n_held_second   = r_held_second;
        n_buttons_valid = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase      = PH_SETUP;
                    n_wait_count = '0;
                end
            end
            PH_SETUP: begin
                n_wait_count = wait_inc;
                if (count_done) begin
                    n_phase      = PH_LOW;
                    n_wait_count = '0;
                    n_bit_index  = '0;
                    n_byte_index = '0;
                end
            end
            PH_LOW: begin
                n_wait_count = wait_inc;
                if (count_done) begin
                    // Sample data at the end of the low half, LSB first
                    n_receive_shift = {i_data_pin, r_receive_shift[BYTE_W-1:1]};
                    if (r_bit_index == LAST_BIT) begin
                        if (r_byte_index == FIRST_BTN_BYTE) begin
                            n_held_first = n_receive_shift;
                        end else if (r_byte_index == SECOND_BTN_BYTE) begin
                            n_held_second = n_receive_shift;
                        end
                    end
                    n_phase      = PH_HIGH;
                    n_wait_count = '0;
                end
            end
            PH_HIGH: begin
                n_wait_count = wait_inc;
                if (count_done) begin
                    n_wait_count = '0;
                    if (r_bit_index == LAST_BIT) begin
                        n_bit_index = '0;
                        if (byte_inc >= FRAME_BYTES) begin
                            n_byte_index    = '0;
                            n_phase         = PH_IDLE;
                            n_buttons_valid = 1'b1;
                        end else begin
                            n_byte_index = byte_inc;
                            n_phase      = PH_LOW;
                        end
                    end else begin
                        n_bit_index = r_bit_index + t_idx'(1);
                        n_phase     = PH_LOW;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_half_period <= RST_BIT_HALF_PERIOD;
            r_attention_setup <= RST_ATTENTION_SETUP;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BIT_HALF_PERIOD) begin
                r_bit_half_period <= i_cfg_data;
            end else if (i_cfg_index == CFG_ATTENTION_SETUP) begin
                r_attention_setup <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_wait_count    <= '0;
            r_bit_index     <= '0;
            r_byte_index    <= '0;
            r_receive_shift <= '0;
            r_held_first    <= '0;
            r_held_second   <= '0;
            r_buttons_valid <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase         <= n_phase;
                r_wait_count    <= n_wait_count;
                r_bit_index     <= n_bit_index;
                r_byte_index    <= n_byte_index;
                r_receive_shift <= n_receive_shift;
                r_held_first    <= n_held_first;
                r_held_second   <= n_held_second;
                r_buttons_valid <= n_buttons_valid;
                r_out_valid     <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result beat reflects the state after the last accepted tick
    always_comb begin
        cmd_byte      = tx_byte(r_byte_index);
        o_command_pin = 1'b1;
        if (r_phase == PH_LOW || r_phase == PH_HIGH) begin
            o_command_pin = cmd_byte[r_bit_index];
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_attention_pin      = (r_phase == PH_IDLE);
    assign o_clock_pin          = (r_phase != PH_LOW);
    assign o_busy_res           = (r_phase != PH_IDLE);
    assign o_buttons_valid      = r_buttons_valid;
    assign o_first_button_byte  = r_held_first;
    assign o_second_button_byte = r_held_second;

`ifndef SYNTHESIS
    a_valid_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buttons_valid |-> (r_phase == PH_IDLE))
        else $error("buttons valid outside idle");

    a_byte_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LOW || r_phase == PH_HIGH) |-> (r_byte_index < FRAME_BYTES))
        else $error("byte index beyond frame");

    a_start_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_IDLE && i_start_req) |=> (r_phase == PH_SETUP))
        else $error("start request not taken while idle");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_phase)
            && $stable(r_buttons_valid) && $stable(r_held_first)))
        else $error("state moved while result stalled");

    a_zero_on_new_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase != PH_IDLE && n_phase != r_phase) |=> (r_wait_count == '0))
        else $error("counter not cleared on phase change");
`endif

endmodule
